>>> rtl/aed_pkg.sv
`default_nettype none

package aed_pkg;

    localparam int LEVEL_BITS     = 24;
    localparam int CFG_INDEX_BITS = 2;

    localparam int MUL_BITS     = 32;
    localparam int DIGIT_BITS   = 8;
    localparam int MUL_DIGITS   = MUL_BITS / DIGIT_BITS;
    localparam int MUL_CNT_BITS = $clog2(MUL_DIGITS);

    localparam int MANT_BITS     = 31;
    localparam int LOG_FRAC_BITS = 16;

    localparam int SCALED_BITS = 42;
    localparam int DB_SHIFT    = 24;
    localparam int DB_MAG_BITS = SCALED_BITS - DB_SHIFT;

    localparam logic [MUL_BITS-1:0]    DB_SCALE     = 32'd394566;
    localparam logic [SCALED_BITS-1:0] DB_ROUND     = 42'd8388608;
    localparam logic [DB_MAG_BITS-1:0] DB_FLOOR_MAG = 18'd24576;
    localparam logic [LEVEL_BITS-1:0]  DB_FLOOR_CODE =
        LEVEL_BITS'(0) - LEVEL_BITS'(DB_FLOOR_MAG);

    localparam logic [1:0] MODE_MS  = 2'd1;
    localparam logic [1:0] MODE_RMS = 2'd2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_MODE    = 2'd2,
        CFG_DB      = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

>>> rtl/aed_if.sv
`default_nettype none

interface aed_sample_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface aed_level_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [aed_pkg::LEVEL_BITS-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink (input valid, input level, output ready);
endinterface

interface aed_cfg_if #(
    parameter int DATA_BITS = 16
);
    logic                 valid;
    logic                 ready;
    aed_pkg::cfg_index_t  index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/audio_envelope_detector.sv
// Envelope detector: peak, mean square or RMS, with attack/release smoothing.
// Channels: cfg writes attack_coeff (0), release_coeff (1), detect_mode (2)
// and db_output (3); it is always ready. samples takes one signed sample per
// request; levels returns one level per request, linear Q0.23 or Q8.8 dB.
// One item is processed at a time by a sequencer around one shared
// 32x8-bit digit-serial multiplier and a one bit-pair-per-cycle square
// root. Each request is rectified, squared for MS and RMS, smoothed,
// rooted for RMS and, for dB, normalized, put through 16 squarings for
// the log fraction bits and scaled for dB. A new sample is
// taken once the sequencer is back in idle.
// The result register decouples the output: a stalled receiver holds the
// level, and the next result waits in the sequencer until it is taken.
// Reset clears the envelope, all registers and the output valid.
// Write configuration only while no request is in flight.
`default_nettype none

module audio_envelope_detector #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    aed_cfg_if.sink      cfg,
    aed_sample_if.sink   samples,
    aed_level_if.source  levels
);
    import aed_pkg::*;

    localparam int FRAC      = SAMPLE_BITS - 1;
    localparam int STEP_MAX  = (FRAC > LOG_FRAC_BITS) ? FRAC : LOG_FRAC_BITS;
    localparam int CNT_BITS  = $clog2(STEP_MAX);
    localparam int IP_BITS   = $clog2(SAMPLE_BITS + 1);
    localparam int NEG_BITS  = IP_BITS + LOG_FRAC_BITS;
    localparam int SUM_BITS  = MUL_BITS + DIGIT_BITS;
    localparam int ATT_BITS  = COEFF_BITS + FRAC + 1;
    localparam logic [FRAC-1:0] MAG_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQUARE_END,
        ST_SMOOTH_PREP,
        ST_SMOOTH,
        ST_SMOOTH_END,
        ST_SQRT,
        ST_LEVEL,
        ST_LOG_NORM,
        ST_LOG_MUL,
        ST_LOG_STEP,
        ST_SCALE_MUL,
        ST_SCALE_END,
        ST_DELIVER
    } state_t;

    state_t                  state_reg, state_next;
    logic [COEFF_BITS-1:0]   attack_reg, attack_next;
    logic [COEFF_BITS-1:0]   release_reg, release_next;
    logic [1:0]              mode_reg, mode_next;
    logic                    db_reg, db_next;
    logic [FRAC-1:0]         env_reg, env_next;
    logic [FRAC-1:0]         x_reg, x_next;
    logic                    ge_reg, ge_next;
    logic [FRAC-1:0]         lvl_reg, lvl_next;
    logic [MUL_BITS-1:0]     mul_a_reg, mul_a_next;
    logic [MUL_BITS-1:0]     mul_b_reg, mul_b_next;
    logic [MUL_BITS-1:0]     mul_hi_reg, mul_hi_next;
    logic [MUL_BITS-1:0]     mul_lo_reg, mul_lo_next;
    logic [MUL_CNT_BITS-1:0] mul_cnt_reg, mul_cnt_next;
    logic [2*FRAC-1:0]       rad_reg, rad_next;
    logic [FRAC-1:0]         rem_reg, rem_next;
    logic [FRAC-1:0]         root_reg, root_next;
    logic [CNT_BITS-1:0]     iter_reg, iter_next;
    logic [MANT_BITS-1:0]    m_reg, m_next;
    logic [IP_BITS-1:0]      ip_reg, ip_next;
    logic [LOG_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [LEVEL_BITS-1:0]   result_reg, result_next;
    logic [LEVEL_BITS-1:0]   level_reg, level_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    mul_busy;
    logic                    mul_last;
    logic                    mul_load;
    logic [MUL_BITS-1:0]     mul_load_a;
    logic [MUL_BITS-1:0]     mul_load_b;
    logic [SUM_BITS-1:0]     mul_sum;
    logic [2*MUL_BITS-1:0]   mul_product;

    logic [SAMPLE_BITS-1:0]  neg_sample;
    logic [FRAC-1:0]         rect_mag;
    logic                    squared_mode;
    logic                    env_ge;
    logic [FRAC-1:0]         diff;
    logic [COEFF_BITS-1:0]   coeff_sel;
    logic [FRAC-1:0]         nv_ge;
    logic [ATT_BITS-1:0]     att_round;
    logic [FRAC:0]           att_q;
    logic [FRAC-1:0]         nv_lt;
    logic [FRAC-1:0]         smooth_nv;
    logic [FRAC+1:0]         rem_sh;
    logic [FRAC+1:0]         trial;
    logic                    sqrt_fit;
    logic [FRAC+1:0]         sqrt_diff;
    logic [FRAC-1:0]         root_new;
    logic [MANT_BITS:0]      sq_top;
    logic [MANT_BITS-1:0]    m_sq;
    logic [LOG_FRAC_BITS-1:0] frac_new;
    logic [NEG_BITS-1:0]     neg_log;
    logic [SCALED_BITS-1:0]  scaled_rnd;
    logic [DB_MAG_BITS-1:0]  db_mag;
    logic [LEVEL_BITS-1:0]   db_code;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == ST_IDLE);
    assign levels.valid  = out_valid_reg;
    assign levels.level  = $signed(level_reg);

    assign neg_sample   = SAMPLE_BITS'(0) - $unsigned(samples.sample);
    assign rect_mag     = samples.sample[SAMPLE_BITS-1]
                        ? (neg_sample[FRAC] ? MAG_MAX : neg_sample[FRAC-1:0])
                        : samples.sample[FRAC-1:0];
    assign squared_mode = mode_reg inside {MODE_MS, MODE_RMS};

    assign mul_busy    = (state_reg == ST_SQUARE) || (state_reg == ST_SMOOTH)
                      || (state_reg == ST_LOG_MUL) || (state_reg == ST_SCALE_MUL);
    assign mul_last    = (mul_cnt_reg == MUL_CNT_BITS'(MUL_DIGITS - 1));
    assign mul_sum     = {{DIGIT_BITS{1'b0}}, mul_hi_reg}
                       + SUM_BITS'(mul_a_reg) * SUM_BITS'(mul_b_reg[DIGIT_BITS-1:0]);
    assign mul_product = {mul_hi_reg, mul_lo_reg};

    assign env_ge    = (env_reg >= x_reg);
    assign diff      = env_ge ? (env_reg - x_reg) : (x_reg - env_reg);
    assign coeff_sel = env_ge ? release_reg : attack_reg;

    assign nv_ge     = x_reg + mul_product[COEFF_BITS +: FRAC];
    assign att_round = {1'b0, mul_product[COEFF_BITS+FRAC-1:0]}
                     + ATT_BITS'({COEFF_BITS{1'b1}});
    assign att_q     = att_round[COEFF_BITS +: FRAC+1];
    assign nv_lt     = (att_q > {1'b0, x_reg}) ? '0 : (x_reg - att_q[FRAC-1:0]);
    assign smooth_nv = ge_reg ? nv_ge : nv_lt;

    assign rem_sh    = {rem_reg, rad_reg[2*FRAC-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign sqrt_fit  = (rem_sh >= trial);
    assign sqrt_diff = rem_sh - trial;
    assign root_new  = {root_reg[FRAC-2:0], sqrt_fit};

    assign sq_top    = mul_product[MANT_BITS-1 +: MANT_BITS+1];
    assign m_sq      = sq_top[MANT_BITS] ? sq_top[MANT_BITS:1] : sq_top[MANT_BITS-1:0];
    assign frac_new  = {frac_reg[LOG_FRAC_BITS-2:0], sq_top[MANT_BITS]};
    assign neg_log   = {ip_reg, LOG_FRAC_BITS'(0)} - NEG_BITS'(frac_new);

    assign scaled_rnd = mul_product[SCALED_BITS-1:0] + DB_ROUND;
    assign db_mag     = scaled_rnd[DB_SHIFT +: DB_MAG_BITS];
    assign db_code    = (db_mag > DB_FLOOR_MAG) ? DB_FLOOR_CODE
                      : LEVEL_BITS'(0) - LEVEL_BITS'(db_mag);

    always_comb
    begin
        state_next     = state_reg;
        attack_next    = attack_reg;
        release_next   = release_reg;
        mode_next      = mode_reg;
        db_next        = db_reg;
        env_next       = env_reg;
        x_next         = x_reg;
        ge_next        = ge_reg;
        lvl_next       = lvl_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_hi_next    = mul_hi_reg;
        mul_lo_next    = mul_lo_reg;
        mul_cnt_next   = mul_cnt_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        iter_next      = iter_reg;
        m_next         = m_reg;
        ip_next        = ip_reg;
        frac_next      = frac_reg;
        result_next    = result_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        mul_load       = 1'b0;
        mul_load_a     = '0;
        mul_load_b     = '0;

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ATTACK:  attack_next  = cfg.data;
                CFG_RELEASE: release_next = cfg.data;
                CFG_MODE:    mode_next    = cfg.data[1:0];
                CFG_DB:      db_next      = cfg.data[0];
                default:     ;
            endcase
        end

        // shift one multiplier digit into the accumulator
        if (mul_busy)
        begin
            mul_hi_next  = mul_sum[SUM_BITS-1:DIGIT_BITS];
            mul_lo_next  = {mul_sum[DIGIT_BITS-1:0], mul_lo_reg[MUL_BITS-1:DIGIT_BITS]};
            mul_b_next   = mul_b_reg >> DIGIT_BITS;
            mul_cnt_next = mul_cnt_reg + 1'b1;
        end

        if (out_valid_reg && levels.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    x_next = rect_mag;
                    if (squared_mode)
                    begin
                        mul_load   = 1'b1;
                        mul_load_a = MUL_BITS'(rect_mag);
                        mul_load_b = MUL_BITS'(rect_mag);
                        state_next = ST_SQUARE;
                    end
                    else
                    begin
                        state_next = ST_SMOOTH_PREP;
                    end
                end
            end
            ST_SQUARE:
            begin
                if (mul_last)
                begin
                    state_next = ST_SQUARE_END;
                end
            end
            ST_SQUARE_END:
            begin
                x_next     = mul_product[FRAC +: FRAC];
                state_next = ST_SMOOTH_PREP;
            end
            ST_SMOOTH_PREP:
            begin
                ge_next    = env_ge;
                mul_load   = 1'b1;
                mul_load_a = MUL_BITS'(diff);
                mul_load_b = MUL_BITS'(coeff_sel);
                state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                if (mul_last)
                begin
                    state_next = ST_SMOOTH_END;
                end
            end
            ST_SMOOTH_END:
            begin
                env_next = smooth_nv;
                lvl_next = smooth_nv;
                if (mode_reg == MODE_RMS)
                begin
                    rad_next   = {smooth_nv, FRAC'(0)};
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = CNT_BITS'(FRAC - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_SQRT:
            begin
                rem_next  = sqrt_fit ? sqrt_diff[FRAC-1:0] : rem_sh[FRAC-1:0];
                root_next = root_new;
                rad_next  = rad_reg << 2;
                if (iter_reg == '0)
                begin
                    lvl_next   = root_new;
                    state_next = ST_LEVEL;
                end
                else
                begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_LEVEL:
            begin
                if (!db_reg)
                begin
                    result_next = LEVEL_BITS'(lvl_reg);
                    state_next  = ST_DELIVER;
                end
                else if (lvl_reg == '0)
                begin
                    result_next = DB_FLOOR_CODE;
                    state_next  = ST_DELIVER;
                end
                else
                begin
                    m_next     = MANT_BITS'(lvl_reg) << (MANT_BITS - FRAC);
                    ip_next    = IP_BITS'(1);
                    state_next = ST_LOG_NORM;
                end
            end
            ST_LOG_NORM:
            begin
                if (m_reg[MANT_BITS-1])
                begin
                    mul_load   = 1'b1;
                    mul_load_a = MUL_BITS'(m_reg);
                    mul_load_b = MUL_BITS'(m_reg);
                    frac_next  = '0;
                    iter_next  = CNT_BITS'(LOG_FRAC_BITS - 1);
                    state_next = ST_LOG_MUL;
                end
                else
                begin
                    m_next  = m_reg << 1;
                    ip_next = ip_reg + 1'b1;
                end
            end
            ST_LOG_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ST_LOG_STEP;
                end
            end
            ST_LOG_STEP:
            begin
                m_next    = m_sq;
                frac_next = frac_new;
                mul_load  = 1'b1;
                if (iter_reg == '0)
                begin
                    mul_load_a = MUL_BITS'(neg_log);
                    mul_load_b = DB_SCALE;
                    state_next = ST_SCALE_MUL;
                end
                else
                begin
                    mul_load_a = MUL_BITS'(m_sq);
                    mul_load_b = MUL_BITS'(m_sq);
                    iter_next  = iter_reg - 1'b1;
                    state_next = ST_LOG_MUL;
                end
            end
            ST_SCALE_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ST_SCALE_END;
                end
            end
            ST_SCALE_END:
            begin
                result_next = db_code;
                state_next  = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                // hold until the output register is free
                if (!out_valid_reg || levels.ready)
                begin
                    level_next     = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mul_load)
        begin
            mul_a_next   = mul_load_a;
            mul_b_next   = mul_load_b;
            mul_hi_next  = '0;
            mul_lo_next  = '0;
            mul_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            attack_reg    <= '0;
            release_reg   <= '0;
            mode_reg      <= '0;
            db_reg        <= 1'b0;
            env_reg       <= '0;
            x_reg         <= '0;
            ge_reg        <= 1'b0;
            lvl_reg       <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_hi_reg    <= '0;
            mul_lo_reg    <= '0;
            mul_cnt_reg   <= '0;
            rad_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            iter_reg      <= '0;
            m_reg         <= '0;
            ip_reg        <= '0;
            frac_reg      <= '0;
            result_reg    <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            attack_reg    <= attack_next;
            release_reg   <= release_next;
            mode_reg      <= mode_next;
            db_reg        <= db_next;
            env_reg       <= env_next;
            x_reg         <= x_next;
            ge_reg        <= ge_next;
            lvl_reg       <= lvl_next;
            mul_a_reg     <= mul_a_next;
            mul_b_reg     <= mul_b_next;
            mul_hi_reg    <= mul_hi_next;
            mul_lo_reg    <= mul_lo_next;
            mul_cnt_reg   <= mul_cnt_next;
            rad_reg       <= rad_next;
            rem_reg       <= rem_next;
            root_reg      <= root_next;
            iter_reg      <= iter_next;
            m_reg         <= m_next;
            ip_reg        <= ip_next;
            frac_reg      <= frac_next;
            result_reg    <= result_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    ap_env_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_SMOOTH_END |=> $stable(env_reg))
        else $error("envelope changed outside the smoother update");

    ap_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SMOOTH_END |->
            (ge_reg ? (smooth_nv <= env_reg && smooth_nv >= x_reg) : (smooth_nv <= x_reg)))
        else $error("smoothed value outside the input and envelope range");

    ap_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOG_MUL |-> m_reg[MANT_BITS-1])
        else $error("log mantissa not normalized while squaring");

    ap_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> mul_cnt_reg == '0)
        else $error("multiplier digit count not at rest in idle");

    ap_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DELIVER)
        else $error("output valid raised without a delivered result");
`endif

endmodule

`default_nettype wire
